/* rtl/core/mnt_pkg.sv */
// ----------------------------------------------------------------------------
// mnt_pkg
// Shared constants, types and helpers of the MIDI note tracker.
// ----------------------------------------------------------------------------
package mnt_pkg;

    localparam int CHANNELS     = 16;
    localparam int NOTES        = 128;
    localparam int MAX_RELEASES = 64;
    localparam int TIME_BITS    = 32;

    localparam int CH_W    = $clog2(CHANNELS);
    localparam int NOTE_W  = $clog2(NOTES);
    localparam int START_W = NOTE_W + CH_W;
    localparam int CNT_W   = $clog2(MAX_RELEASES + 1);

    // Message types (high nibble of the status byte).
    localparam logic [7:0] TYPE_MASK     = 8'hF0;
    localparam logic [7:0] CHAN_MASK     = 8'h0F;
    localparam logic [7:0] TYPE_NOTE_OFF = 8'h80;
    localparam logic [7:0] TYPE_NOTE_ON  = 8'h90;
    localparam logic [7:0] TYPE_CONTROL  = 8'hB0;
    localparam logic [7:0] TYPE_PROGRAM  = 8'hC0;
    localparam logic [6:0] CTRL_VOLUME   = 7'd7;

    // Request actions.
    localparam logic [1:0] ACT_MESSAGE = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;
    localparam logic [1:0] ACT_VOLUME  = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_MSG    = 2'd0;
    localparam logic [1:0] KIND_VOLUME = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_TWO  = 2'd2;
    localparam logic [1:0] LEN_FULL = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_MAX_TICKS   = 1'b0;
    localparam logic CFG_GLOBAL_MODE = 1'b1;

    localparam logic [31:0]        RST_MAX_TICKS = 32'd1120;
    localparam logic [7:0]         RST_MASTER    = 8'd192;
    localparam logic [6:0]         RST_CH_VOLUME = 7'd127;
    localparam logic [8:0]         VOLUME_FULL   = 9'd256;

    // Access request to the note table.
    typedef struct packed {
        logic [NOTE_W-1:0]    row_rd_addr;
        logic                 row_wr_en;
        logic [NOTE_W-1:0]    row_wr_addr;
        logic [CHANNELS-1:0]  row_wr_data;
        logic [START_W-1:0]   start_rd_addr;
        logic                 start_wr_en;
        logic [START_W-1:0]   start_wr_addr;
        logic [TIME_BITS-1:0] start_wr_data;
        logic                 clear;
    } t_tbl_req;

    // Channel volume times master volume (Q0.8).
    function automatic logic [7:0] f_scale(input logic [6:0] v, input logic [7:0] m);
        logic [14:0] p;
        p = 15'(v) * 15'(m);
        return {1'b0, p[14:8]};
    endfunction

endpackage

/* rtl/core/midi_note_tracker_with_stuck_release.sv */
// ----------------------------------------------------------------------------
// midi_note_tracker_with_stuck_release
// Forwards MIDI messages, tracks sounding notes and releases stuck ones.
// ----------------------------------------------------------------------------
// One request is handled at a time. A message reads its bitmap row, then
// forwards the message and, for a note on or off, writes the row back. A stop
// sends one result and a volume change one, or one per channel when each
// channel's volume is re-sent. A tick walks the 128 bitmap rows, reading each
// row. A row that holds any sounding note then visits each channel in turn
// and, for every sounding note, reads its start time and compares its age.
// The walk ends early once 64 notes are released.
// Results wait for the output register, which stalls the walk when full.
// Configuration writes are taken only while the block is idle and no request
// is offered.
module midi_note_tracker_with_stuck_release
    import mnt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_status,
    input  logic [6:0]  i_data_first,
    input  logic [6:0]  i_data_second,
    input  logic [8:0]  i_volume,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_status,
    output logic [6:0]  o_out_data_first,
    output logic [7:0]  o_out_data_second,
    output logic [1:0]  o_msg_len,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MSG_RD = 4'd1;
    localparam logic [3:0] S_MSG    = 4'd2;
    localparam logic [3:0] S_T_ROW  = 4'd3;
    localparam logic [3:0] S_T_ROWD = 4'd4;
    localparam logic [3:0] S_T_CH   = 4'd5;
    localparam logic [3:0] S_T_CMP  = 4'd6;
    localparam logic [3:0] S_T_END  = 4'd7;
    localparam logic [3:0] S_STOP   = 4'd8;
    localparam logic [3:0] S_VOLG   = 4'd9;
    localparam logic [3:0] S_VOLC   = 4'd10;

    logic [3:0]           r_state, n_state;
    logic [NOTE_W-1:0]    r_i, n_i;
    logic [CH_W-1:0]      r_c, n_c;
    logic [CHANNELS-1:0]  r_row, n_row;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_pend_vld, n_pend_vld;
    logic [CH_W-1:0]      r_pend_ch, n_pend_ch;
    logic [NOTE_W-1:0]    r_pend_note, n_pend_note;
    logic [7:0]           r_st, n_st;
    logic [6:0]           r_d2, n_d2;
    logic [TIME_BITS-1:0] r_clock, n_clock;
    logic [31:0]          r_max;
    logic                 r_gmode;
    logic [7:0]           r_master, n_master;
    logic [6:0]           r_chvol [CHANNELS];
    logic                 chvol_we;
    logic [CH_W-1:0]      chvol_addr;
    logic                 r_o_valid, n_o_valid;
    logic [1:0]           r_o_kind, n_o_kind;
    logic [7:0]           r_o_status, n_o_status;
    logic [6:0]           r_o_d1, n_o_d1;
    logic [7:0]           r_o_d2, n_o_d2;
    logic [1:0]           r_o_len, n_o_len;
    logic                 r_o_last, n_o_last;

    t_tbl_req             tbl_req;
    logic [CHANNELS-1:0]  tbl_row;
    logic [TIME_BITS-1:0] tbl_start;

    logic                 out_free;
    logic                 adv;
    logic [CHANNELS-1:0]  row_now;
    logic [7:0]           msg_type;
    logic [CH_W-1:0]      msg_ch;
    logic                 is_cc7;
    logic [7:0]           sent2;
    logic [TIME_BITS-1:0] age;
    logic                 rel;
    logic [8:0]           vol_sat;
    logic [10:0]          vol_x3;

    mnt_note_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_row   (tbl_row),
        .o_start (tbl_start)
    );

    assign out_free = !r_o_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;

    assign msg_type = r_st & TYPE_MASK;
    assign msg_ch   = CH_W'(r_st & CHAN_MASK);
    // The first data byte of a message is held in r_i.
    assign is_cc7   = (msg_type == TYPE_CONTROL) && (r_i == CTRL_VOLUME) && !r_gmode;
    assign age      = r_clock - tbl_start;
    assign rel      = (age > r_max);
    assign vol_sat  = (i_volume > VOLUME_FULL) ? VOLUME_FULL : i_volume;
    assign vol_x3   = 11'(vol_sat) * 11'd3;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_c         = r_c;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_pend_vld  = r_pend_vld;
        n_pend_ch   = r_pend_ch;
        n_pend_note = r_pend_note;
        n_st        = r_st;
        n_d2        = r_d2;
        n_clock     = r_clock;
        n_master    = r_master;
        n_o_valid   = r_o_valid && !i_out_ready;
        n_o_kind    = r_o_kind;
        n_o_status  = r_o_status;
        n_o_d1      = r_o_d1;
        n_o_d2      = r_o_d2;
        n_o_len     = r_o_len;
        n_o_last    = r_o_last;
        chvol_we    = 1'b0;
        chvol_addr  = msg_ch;
        adv         = 1'b0;
        row_now     = r_row;
        sent2       = 8'd0;

        tbl_req               = '0;
        tbl_req.row_rd_addr   = r_i;
        tbl_req.start_rd_addr = {r_i, r_c};
        tbl_req.row_wr_addr   = r_i;
        tbl_req.start_wr_addr = {r_i, msg_ch};
        tbl_req.start_wr_data = r_clock;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_action)
                        ACT_MESSAGE: begin
                            n_st    = i_status;
                            n_d2    = i_data_second;
                            n_o_d1  = r_o_d1;
                            n_i     = i_data_first;
                            n_state = S_MSG_RD;
                        end
                        ACT_TICK: begin
                            n_clock    = r_clock + 1'b1;
                            n_i        = '0;
                            n_cnt      = '0;
                            n_pend_vld = 1'b0;
                            n_state    = S_T_ROW;
                        end
                        ACT_STOP: begin
                            n_state = S_STOP;
                        end
                        default: begin
                            n_master = vol_x3[9:2];
                            n_c      = '0;
                            n_state  = r_gmode ? S_VOLG : S_VOLC;
                        end
                    endcase
                end
            end
            S_MSG_RD: begin
                n_state = S_MSG;
            end
            S_MSG: begin
                if (out_free) begin
                    sent2 = is_cc7 ? f_scale(r_d2, r_master) : {1'b0, r_d2};
                    if (is_cc7) begin
                        chvol_we = 1'b1;
                    end
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_MSG;
                    n_o_status = r_st;
                    n_o_d1     = r_i;
                    n_o_len    = (msg_type == TYPE_PROGRAM) ? LEN_TWO : LEN_FULL;
                    n_o_d2     = (msg_type == TYPE_PROGRAM) ? 8'd0 : sent2;
                    n_o_last   = 1'b1;
                    if (msg_type == TYPE_NOTE_ON && r_d2 != 7'd0) begin
                        tbl_req.row_wr_en   = 1'b1;
                        tbl_req.row_wr_data = tbl_row | (CHANNELS'(1) << msg_ch);
                        tbl_req.start_wr_en = 1'b1;
                    end else if (msg_type == TYPE_NOTE_ON || msg_type == TYPE_NOTE_OFF) begin
                        tbl_req.row_wr_en   = 1'b1;
                        tbl_req.row_wr_data = tbl_row & ~(CHANNELS'(1) << msg_ch);
                    end
                    n_state = S_IDLE;
                end
            end
            S_T_ROW: begin
                n_state = S_T_ROWD;
            end
            S_T_ROWD: begin
                if (tbl_row == '0) begin
                    if (r_i == NOTE_W'(NOTES - 1)) begin
                        n_state = S_T_END;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_T_ROW;
                    end
                end else begin
                    n_row   = tbl_row;
                    n_c     = '0;
                    n_state = S_T_CH;
                end
            end
            S_T_CH: begin
                if (r_row[r_c]) begin
                    n_state = S_T_CMP;
                end else begin
                    adv = 1'b1;
                end
            end
            S_T_CMP: begin
                if (!(rel && r_pend_vld && !out_free)) begin
                    adv = 1'b1;
                    if (rel) begin
                        // The previous release goes out now; this one waits so
                        // that the final release of the tick can be marked.
                        if (r_pend_vld) begin
                            n_o_valid  = 1'b1;
                            n_o_kind   = KIND_MSG;
                            n_o_status = TYPE_NOTE_OFF | 8'(r_pend_ch);
                            n_o_d1     = r_pend_note;
                            n_o_d2     = 8'd0;
                            n_o_len    = LEN_FULL;
                            n_o_last   = 1'b0;
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_ch   = r_c;
                        n_pend_note = r_i;
                        row_now     = r_row & ~(CHANNELS'(1) << r_c);
                        n_cnt       = r_cnt + 1'b1;
                    end
                end
            end
            S_T_END: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_MSG;
                    n_o_status = TYPE_NOTE_OFF | 8'(r_pend_ch);
                    n_o_d1     = r_pend_note;
                    n_o_d2     = 8'd0;
                    n_o_len    = LEN_FULL;
                    n_o_last   = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_STOP: begin
                if (out_free) begin
                    n_o_valid     = 1'b1;
                    n_o_kind      = KIND_STOP;
                    n_o_status    = 8'd0;
                    n_o_d1        = 7'd0;
                    n_o_d2        = 8'd0;
                    n_o_len       = LEN_NONE;
                    n_o_last      = 1'b1;
                    tbl_req.clear = 1'b1;
                    n_clock       = '0;
                    n_state       = S_IDLE;
                end
            end
            S_VOLG: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_VOLUME;
                    n_o_status = 8'd0;
                    n_o_d1     = 7'd0;
                    n_o_d2     = r_master;
                    n_o_len    = LEN_NONE;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_VOLC: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_MSG;
                    n_o_status = TYPE_CONTROL | 8'(r_c);
                    n_o_d1     = CTRL_VOLUME;
                    n_o_d2     = f_scale(r_chvol[r_c], r_master);
                    n_o_len    = LEN_FULL;
                    n_o_last   = (r_c == CH_W'(CHANNELS - 1));
                    if (r_c == CH_W'(CHANNELS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Move to the next channel of the row, or write the row back and
        // go on with the next row.
        if (adv) begin
            n_row = row_now;
            if (n_cnt == CNT_W'(MAX_RELEASES) || r_c == CH_W'(CHANNELS - 1)) begin
                tbl_req.row_wr_en   = 1'b1;
                tbl_req.row_wr_data = row_now;
                if (n_cnt == CNT_W'(MAX_RELEASES) || r_i == NOTE_W'(NOTES - 1)) begin
                    n_state = S_T_END;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_T_ROW;
                end
            end else begin
                n_c     = r_c + 1'b1;
                n_state = S_T_CH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_o_valid  <= 1'b0;
            r_clock    <= '0;
            r_max      <= RST_MAX_TICKS;
            r_gmode    <= 1'b0;
            r_master   <= RST_MASTER;
            r_cnt      <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_chvol[k] <= RST_CH_VOLUME;
            end
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_o_valid  <= n_o_valid;
            r_clock    <= n_clock;
            r_master   <= n_master;
            r_cnt      <= n_cnt;
            if (chvol_we) begin
                r_chvol[chvol_addr] <= r_d2;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_TICKS) begin
                    r_max <= i_cfg_data;
                end else begin
                    r_gmode <= i_cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_c         <= n_c;
        r_row       <= n_row;
        r_pend_ch   <= n_pend_ch;
        r_pend_note <= n_pend_note;
        r_st        <= n_st;
        r_d2        <= n_d2;
        r_o_kind    <= n_o_kind;
        r_o_status  <= n_o_status;
        r_o_d1      <= n_o_d1;
        r_o_d2      <= n_o_d2;
        r_o_len     <= n_o_len;
        r_o_last    <= n_o_last;
    end

    assign o_out_valid       = r_o_valid;
    assign o_kind            = r_o_kind;
    assign o_out_status      = r_o_status;
    assign o_out_data_first  = r_o_d1;
    assign o_out_data_second = r_o_d2;
    assign o_msg_len         = r_o_len;
    assign o_last            = r_o_last;

    // The release count of a tick never passes the per-tick limit.
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RELEASES))
        else $error("release count above limit");

    // An age compare is only done for a note whose bit is set.
    a_cmp_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T_CMP) |-> r_row[r_c])
        else $error("age compare on a silent note");

    // A stop result restarts the note clock.
    a_stop_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STOP && out_free) |=> (r_clock == '0 && r_o_kind == KIND_STOP))
        else $error("stop did not restart the clock");

    // Requests are taken only with no release pending.
    a_idle_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("release left pending");

endmodule

/* rtl/core/mnt_note_table.sv */
// ----------------------------------------------------------------------------
// mnt_note_table
// Note-on bitmap and note start times, both as synchronous memories with a
// registered read. Each bitmap row has a valid flag so a stop clears at once.
// ----------------------------------------------------------------------------
module mnt_note_table
    import mnt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tbl_req             i_req,
    output logic [CHANNELS-1:0]  o_row,
    output logic [TIME_BITS-1:0] o_start
);

    logic [CHANNELS-1:0]  r_row_mem   [NOTES];
    logic [TIME_BITS-1:0] r_start_mem [NOTES*CHANNELS];
    logic [NOTES-1:0]     r_vld;
    logic [CHANNELS-1:0]  r_row_q;
    logic                 r_vld_q;
    logic [TIME_BITS-1:0] r_start_q;

    always_ff @(posedge i_clk) begin
        if (i_req.row_wr_en) begin
            r_row_mem[i_req.row_wr_addr] <= i_req.row_wr_data;
        end
        r_row_q <= r_row_mem[i_req.row_rd_addr];
        if (i_req.start_wr_en) begin
            r_start_mem[i_req.start_wr_addr] <= i_req.start_wr_data;
        end
        r_start_q <= r_start_mem[i_req.start_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            r_vld_q <= r_vld[i_req.row_rd_addr];
            if (i_req.clear) begin
                r_vld <= '0;
            end else if (i_req.row_wr_en) begin
                r_vld[i_req.row_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_row   = r_vld_q ? r_row_q : '0;
    assign o_start = r_start_q;

endmodule
